### rtl/core/sbda_pkg.sv
// Shared types and constants for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps
package sbda_pkg;

  localparam int ValueWidth = 32;
  localparam int CharWidth  = 6;
  localparam int DigitWidth = 4;
  localparam int MaxDigits  = 10;
  localparam int IdxWidth   = $clog2(MaxDigits);

  localparam logic [CharWidth-1:0] CharMinus = 6'd45;
  localparam logic [CharWidth-1:0] CharZero  = 6'd48;

  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x
  localparam logic [ValueWidth-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int                    RecipShift = 35;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic q_zero;
    logic idx_zero;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/core/sbda_datapath.sv
// Datapath: magnitude register, divide-by-ten step, digit store and output register.
`timescale 1ns / 1ps
module sbda_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [sbda_pkg::ValueWidth-1:0] value,
  input  sbda_pkg::dp_cmd_t                   cmd,
  output sbda_pkg::dp_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sbda_pkg::CharWidth-1:0]      ascii_char,
  output logic                                last
);
  import sbda_pkg::*;

  logic [ValueWidth-1:0]   mag;
  logic                    neg;
  logic [IdxWidth-1:0]     cnt;
  logic [DigitWidth-1:0]   digits [MaxDigits];

  logic [ValueWidth-1:0]   raw;
  logic [ValueWidth-1:0]   abs_val;
  logic [2*ValueWidth-1:0] prod;
  logic [ValueWidth-1:0]   q;
  logic [DigitWidth-1:0]   q10;
  logic [DigitWidth-1:0]   digit;
  logic [DigitWidth-1:0]   cur_digit;

  assign raw     = value;
  assign abs_val = raw[ValueWidth-1] ? ({ValueWidth{1'b0}} - raw) : raw;

  assign prod  = {{ValueWidth{1'b0}}, mag} * {{ValueWidth{1'b0}}, RecipTen};
  assign q     = ValueWidth'(prod >> RecipShift);
  // only the low nibble of 10*q matters: the remainder is below ten
  assign q10   = {q[0], 3'b000} + {q[2:0], 1'b0};
  assign digit = mag[DigitWidth-1:0] - q10;

  assign cur_digit = digits[cnt];

  assign sts.neg      = neg;
  assign sts.q_zero   = (q == '0);
  assign sts.idx_zero = (cnt == '0);
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= abs_val;
      neg <= raw[ValueWidth-1];
    end else if (cmd.conv) begin
      mag <= q;
    end
    if (cmd.conv) begin
      digits[cnt] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.conv && !sts.q_zero) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.emit_digit && !sts.idx_zero) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      ascii_char <= CharMinus;
      last       <= 1'b0;
    end else if (cmd.emit_digit) begin
      ascii_char <= CharZero + CharWidth'(cur_digit);
      last       <= sts.idx_zero;
    end
  end

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_char == CharMinus && !last) ||
                  (ascii_char >= CharZero && ascii_char <= CharZero + 6'd9))
    else $error("illegal character in output register");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= IdxWidth'(MaxDigits - 1))
    else $error("digit index beyond store");

  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit && sts.idx_zero |=> out_valid && last && ascii_char >= CharZero)
    else $error("final digit not marked last");

  a_free_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
    else $error("emit into an occupied output register");

endmodule

### rtl/core/sbda_ctrl.sv
// Controller: sequences load, digit extraction and character emission.
`timescale 1ns / 1ps
module sbda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sbda_pkg::dp_sts_t sts,
  output sbda_pkg::dp_cmd_t cmd
);
  import sbda_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CONV;
      end
      S_CONV: begin
        if (sts.q_zero) state_next = sts.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        if (sts.out_free) state_next = S_DIGIT;
      end
      S_DIGIT: begin
        if (sts.out_free && sts.idx_zero) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      S_CONV:  cmd.conv       = 1'b1;
      S_SIGN:  cmd.emit_sign  = sts.out_free;
      S_DIGIT: cmd.emit_digit = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_load_to_conv: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CONV)
    else $error("load not followed by conversion");

endmodule

### rtl/core/signed_binary_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//   channel  dir  handshake             payload
//   input    in   in_valid / in_stall   value (signed 32)
//   output   out  out_valid / out_stall ascii_char (6), last
//
// One number with n digits is loaded, then divided by ten once per digit
// (a 32x32 reciprocal multiply per digit), and then emitted one character
// at a time (a minus sign for negative values, then the n digits).
// Synchronous active-high reset clears controller and output valid.
// out_stall holds the output register and pauses emission; in_stall is high
// during reset and whenever a number is in progress.
`timescale 1ns / 1ps
module signed_binary_to_decimal_ascii (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sbda_pkg::ValueWidth-1:0] value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sbda_pkg::CharWidth-1:0]         ascii_char,
  output logic                                   last
);
  import sbda_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sbda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbda_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ascii_char (ascii_char),
    .last       (last)
  );

endmodule
